/* rtl/usp_pkg.sv */
// Shared constants and control/status types for the unique random pick shuffler.
`timescale 1ns / 1ps

package usp_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int RND_W       = 31;
    localparam int PICKS_W     = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int DIFF_W      = DATA_W + 1;
    localparam int DIV_STEPS   = RND_W;
    localparam int DIV_CW      = $clog2(DIV_STEPS);

    localparam logic [1:0] MODE_RESTART = 2'd0;
    localparam logic [1:0] MODE_STEP    = 2'd1;
    localparam logic [1:0] MODE_READ    = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ORDER   = 2'd1;
    localparam logic [1:0] ST_SIZE    = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PICKS = 2'd2;

    typedef struct packed {
        logic       load_in;
        logic       clr_ready;
        logic       commit;
        logic       fill_wr;
        logic       set_ready;
        logic       div_start;
        logic       div_step;
        logic       rd_x;
        logic       rd_step;
        logic       rd_idx;
        logic       cap_a;
        logic       wr_step;
        logic       wr_x;
        logic       out_load;
        logic       out_zero;
        logic [1:0] out_status;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       ready;
        logic       step_ok;
        logic       read_ok;
        logic       order_bad;
        logic       size_bad;
        logic       fill_last;
        logic       div_last;
        logic       out_free;
    } t_stat;

endpackage

/* rtl/usp_ctrl.sv */
// Sequencing state machine for the unique random pick shuffler.
`timescale 1ns / 1ps

module usp_ctrl
    import usp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_FILL = 4'd3;
    localparam logic [3:0] S_DIV  = 4'd4;
    localparam logic [3:0] S_SRDX = 4'd5;
    localparam logic [3:0] S_SRDS = 4'd6;
    localparam logic [3:0] S_SWRS = 4'd7;
    localparam logic [3:0] S_SWRX = 4'd8;
    localparam logic [3:0] S_RRD  = 4'd9;
    localparam logic [3:0] S_RCAP = 4'd10;
    localparam logic [3:0] S_RES  = 4'd11;

    logic [3:0] r_state, n_state;
    logic [1:0] r_code, n_code;
    logic       r_zero, n_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_code  <= ST_OK;
            r_zero  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
            r_zero  <= n_zero;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        n_zero  = r_zero;
        o_cmd   = '0;
        o_cmd.out_status = r_code;
        o_cmd.out_zero   = r_zero;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                // Unless a branch below says otherwise the item is ignored.
                n_code  = ST_IGNORED;
                n_zero  = 1'b1;
                n_state = S_RES;
                case (i_stat.mode)
                    MODE_RESTART: begin
                        n_state = S_CHK;
                    end
                    MODE_STEP: begin
                        if (i_stat.ready && i_stat.step_ok) begin
                            o_cmd.div_start = 1'b1;
                            n_state = S_DIV;
                        end
                    end
                    MODE_READ: begin
                        if (i_stat.ready && i_stat.read_ok) begin
                            n_state = S_RRD;
                        end
                    end
                    default: begin
                        n_state = S_RES;
                    end
                endcase
            end
            S_CHK: begin
                n_zero = 1'b1;
                if (i_stat.order_bad) begin
                    o_cmd.clr_ready = 1'b1;
                    n_code  = ST_ORDER;
                    n_state = S_RES;
                end else if (i_stat.size_bad) begin
                    o_cmd.clr_ready = 1'b1;
                    n_code  = ST_SIZE;
                    n_state = S_RES;
                end else begin
                    o_cmd.commit    = 1'b1;
                    o_cmd.clr_ready = 1'b1;
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                o_cmd.fill_wr = 1'b1;
                if (i_stat.fill_last) begin
                    o_cmd.set_ready = 1'b1;
                    n_code  = ST_OK;
                    n_zero  = 1'b1;
                    n_state = S_RES;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_SRDX;
                end
            end
            S_SRDX: begin
                o_cmd.rd_x = 1'b1;
                n_state = S_SRDS;
            end
            S_SRDS: begin
                o_cmd.rd_step = 1'b1;
                o_cmd.cap_a   = 1'b1;
                n_state = S_SWRS;
            end
            S_SWRS: begin
                o_cmd.wr_step = 1'b1;
                n_state = S_SWRX;
            end
            S_SWRX: begin
                o_cmd.wr_x = 1'b1;
                n_code  = ST_OK;
                n_zero  = 1'b0;
                n_state = S_RES;
            end
            S_RRD: begin
                o_cmd.rd_idx = 1'b1;
                n_state = S_RCAP;
            end
            S_RCAP: begin
                o_cmd.cap_a = 1'b1;
                n_code  = ST_OK;
                n_zero  = 1'b0;
                n_state = S_RES;
            end
            S_RES: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/usp_dpath.sv */
// Datapath of the shuffler: registers, table memory, remainder unit and result register.
`timescale 1ns / 1ps

module usp_dpath
    import usp_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [DATA_W-1:0]           i_cfg_data,
    input  logic [1:0]                  i_mode,
    input  logic [RND_W-1:0]            i_random_word,
    input  logic [IDX_W-1:0]            i_read_index,
    input  logic                        i_out_stall,
    input  t_cmd                        i_cmd,
    output t_stat                       o_stat,
    output logic                        o_out_valid,
    output logic signed [DATA_W-1:0]    o_value,
    output logic [1:0]                  o_status
);

    logic [DATA_W-1:0]  r_lower;
    logic [DATA_W-1:0]  r_upper;
    logic [PICKS_W-1:0] r_picks;

    logic [1:0]         r_mode;
    logic [RND_W-1:0]   r_num;
    logic [IDX_W-1:0]   r_ridx;
    logic [DIFF_W-1:0]  r_diff;

    logic [CNT_W-1:0]   r_size;
    logic [CNT_W-1:0]   r_step;
    logic               r_ready;

    logic [IDX_W-1:0]   r_fill_cnt;
    logic [DATA_W-1:0]  r_fill_val;

    logic [CNT_W-1:0]   r_rem;
    logic [DIV_CW-1:0]  r_div_cnt;

    logic [DATA_W-1:0]  r_table [TABLE_DEPTH];
    logic [DATA_W-1:0]  r_rd_data;
    logic [DATA_W-1:0]  r_a;
    logic [DATA_W-1:0]  r_b;

    logic               r_out_valid;
    logic [DATA_W-1:0]  r_value;
    logic [1:0]         r_status;

    logic [CNT_W:0]     trial;
    logic [IDX_W-1:0]   rd_addr;
    logic [IDX_W-1:0]   wr_addr;
    logic [DATA_W-1:0]  wr_data;
    logic               wr_en;
    logic               rd_en;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower <= '0;
            r_upper <= '0;
            r_picks <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LOWER: r_lower <= i_cfg_data;
                CFG_UPPER: r_upper <= i_cfg_data;
                CFG_PICKS: r_picks <= i_cfg_data[PICKS_W-1:0];
                default:   r_lower <= r_lower;
            endcase
        end
    end

    // Item capture; the interval width is taken at once from the stable bounds.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode <= i_mode;
            r_num  <= i_random_word;
            r_ridx <= i_read_index;
            r_diff <= DIFF_W'($signed({r_upper[DATA_W-1], r_upper})
                              - $signed({r_lower[DATA_W-1], r_lower}));
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[RND_W-2:0], 1'b0};
        end
    end

    // Shuffle state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size  <= '0;
            r_step  <= '0;
            r_ready <= 1'b0;
        end else begin
            if (i_cmd.clr_ready) begin
                r_ready <= 1'b0;
            end else if (i_cmd.set_ready) begin
                r_ready <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_size <= CNT_W'(r_diff[CNT_W-1:0] + CNT_W'(1));
                r_step <= '0;
            end else if (i_cmd.wr_x) begin
                r_step <= CNT_W'(r_step + CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_fill_cnt <= '0;
            r_fill_val <= r_lower;
        end else if (i_cmd.fill_wr) begin
            r_fill_cnt <= IDX_W'(r_fill_cnt + IDX_W'(1));
            r_fill_val <= DATA_W'(r_fill_val + DATA_W'(1));
        end
    end

    // Restoring remainder, one dividend bit per cycle, most significant first.
    assign trial = {r_rem, r_num[RND_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= DIV_CW'(r_div_cnt + DIV_CW'(1));
            if (trial >= {1'b0, r_size}) begin
                r_rem <= CNT_W'(trial - {1'b0, r_size});
            end else begin
                r_rem <= CNT_W'(trial);
            end
        end
    end

    // Table memory: one write port, one registered read port.
    always_comb begin
        rd_addr = r_ridx;
        if (i_cmd.rd_x) begin
            rd_addr = r_rem[IDX_W-1:0];
        end else if (i_cmd.rd_step) begin
            rd_addr = r_step[IDX_W-1:0];
        end
        rd_en = i_cmd.rd_x | i_cmd.rd_step | i_cmd.rd_idx;

        wr_addr = r_rem[IDX_W-1:0];
        wr_data = r_b;
        if (i_cmd.fill_wr) begin
            wr_addr = r_fill_cnt;
            wr_data = r_fill_val;
        end else if (i_cmd.wr_step) begin
            wr_addr = r_step[IDX_W-1:0];
            wr_data = r_a;
        end
        wr_en = i_cmd.fill_wr | i_cmd.wr_step | i_cmd.wr_x;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_table[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_a) begin
            r_a <= r_rd_data;
        end
        if (i_cmd.wr_step) begin
            r_b <= r_rd_data;
        end
    end

    // Result register; it frees as soon as the receiver takes the item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_value  <= i_cmd.out_zero ? '0 : r_a;
            r_status <= i_cmd.out_status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = $signed(r_value);
    assign o_status    = r_status;

    always_comb begin
        o_stat.mode      = r_mode;
        o_stat.ready     = r_ready;
        o_stat.step_ok   = (32'(r_step) < 32'(r_picks)) && (r_step < r_size);
        o_stat.read_ok   = (CNT_W'(r_ridx) < r_size);
        o_stat.order_bad = r_diff[DIFF_W-1];
        o_stat.size_bad  = (r_diff > DIFF_W'(TABLE_DEPTH - 1))
                         || (DIFF_W'(r_picks) > DIFF_W'(r_diff + DIFF_W'(1)));
        o_stat.fill_last = (CNT_W'(r_fill_cnt) == CNT_W'(r_size - CNT_W'(1)));
        o_stat.div_last  = (r_div_cnt == DIV_CW'(DIV_STEPS - 1));
        o_stat.out_free  = !r_out_valid || !i_out_stall;
    end

endmodule

/* rtl/unique_random_pick_shuffler_core.sv */
// Top level of the unique random pick shuffler: controller joined to datapath.
`timescale 1ns / 1ps
// A restart checks the bounds and then fills the table, one entry per cycle; a
// shuffle step runs the bit-serial remainder unit and then the read-modify-write
// swap (S_SRDX, S_SRDS, S_SWRS, S_SWRX) over the table's one read and one write port;
// a read fetches one entry. One item is in work at a time; the next is taken as
// soon as the result is in the output register. Reset clears the control state,
// the configuration registers and the ready flag; the table is not cleared.

module unique_random_pick_shuffler_core
    import usp_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [DATA_W-1:0]           i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_mode,
    input  logic [RND_W-1:0]            i_random_word,
    input  logic [IDX_W-1:0]            i_read_index,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [DATA_W-1:0]    o_value,
    output logic [1:0]                  o_status
);

    // The controller walks each item through its steps: a restart checks the
    // bounds and then fills the table one entry per cycle, a shuffle step runs
    // the remainder unit and then swaps two entries with two reads and two
    // writes, and a read fetches one entry. Every item ends with one result.
    t_cmd  cmd;
    t_stat stat;

    usp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // The datapath owns the configuration registers, the table memory, the
    // remainder unit and the output register, so a finished item can wait
    // there while the controller already takes the next one.
    usp_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_mode        (i_mode),
        .i_random_word (i_random_word),
        .i_read_index  (i_read_index),
        .i_out_stall   (i_out_stall),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .o_value       (o_value),
        .o_status      (o_status)
    );

endmodule
